// ===== rtl/core/scl_pkg.sv =====
package scl_pkg;

	// one input request
	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       end_of_line;
	} cmd_t;

	// one result request
	typedef struct packed {
		logic [7:0] tok_char;
		logic [3:0] tok_kind;
		logic       tok_first;
		logic       last;
	} tok_t;

	localparam int unsigned MAX_TOKS = 3;
	localparam int unsigned CNT_W    = $clog2(MAX_TOKS + 1);

	// all results caused by one input request
	typedef struct packed {
		logic [CNT_W-1:0]      cnt;
		tok_t [MAX_TOKS-1:0]   toks;
	} bundle_t;

	// front to queue
	typedef struct packed {
		logic    wr;
		bundle_t data;
	} q_wr_t;

	// queue to back
	typedef struct packed {
		logic    avail;
		bundle_t data;
	} q_rd_t;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WORD = 3'd1,
		MODE_AMP  = 3'd2,
		MODE_PIPE = 3'd3,
		MODE_DASH = 3'd4
	} mode_t;

	localparam logic [3:0] KIND_WORD     = 4'd0;
	localparam logic [3:0] KIND_SEMI     = 4'd1;
	localparam logic [3:0] KIND_ANDAND   = 4'd2;
	localparam logic [3:0] KIND_AMP      = 4'd3;
	localparam logic [3:0] KIND_OROR     = 4'd4;
	localparam logic [3:0] KIND_PIPE     = 4'd5;
	localparam logic [3:0] KIND_LPAREN   = 4'd6;
	localparam logic [3:0] KIND_RPAREN   = 4'd7;
	localparam logic [3:0] KIND_DASH     = 4'd8;
	localparam logic [3:0] KIND_OTHER    = 4'd9;
	localparam logic [3:0] KIND_LINE_END = 4'd10;

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// outcome of lexing one byte from the idle mode
	typedef struct packed {
		logic  emit;
		tok_t  tok;
		mode_t mode;
	} idle_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic tok_t mk_tok(logic [7:0] c, logic [3:0] kind, logic first);
		tok_t t;
		t.tok_char  = c;
		t.tok_kind  = kind;
		t.tok_first = first;
		t.last      = 1'b0;
		return t;
	endfunction

	function automatic idle_t lex_idle(logic [7:0] c);
		idle_t r;
		r.emit = 1'b1;
		r.mode = MODE_IDLE;
		r.tok  = mk_tok(c, KIND_OTHER, 1'b1);
		if (is_space(c)) begin
			r.emit = 1'b0;
		end else if (is_alnum(c) || c == CH_DOT || c == CH_SLASH) begin
			r.tok.tok_kind = KIND_WORD;
			r.mode         = MODE_WORD;
		end else if (c == CH_SEMI) begin
			r.tok.tok_kind = KIND_SEMI;
		end else if (c == CH_AMP) begin
			r.emit = 1'b0;
			r.mode = MODE_AMP;
		end else if (c == CH_BAR) begin
			r.emit = 1'b0;
			r.mode = MODE_PIPE;
		end else if (c == CH_LPAREN) begin
			r.tok.tok_kind = KIND_LPAREN;
		end else if (c == CH_RPAREN) begin
			r.tok.tok_kind = KIND_RPAREN;
		end else if (c == CH_DASH) begin
			r.tok.tok_kind = KIND_DASH;
			r.mode         = MODE_DASH;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/scl_front.sv =====
module scl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  scl_pkg::cmd_t  cmd,
	input  logic           push,
	input  logic           q_full,
	output scl_pkg::q_wr_t q_wr
);

	scl_pkg::mode_t                  mode_q;
	scl_pkg::mode_t                  mode_c;
	scl_pkg::mode_t                  mode_d;
	scl_pkg::idle_t                  idle;
	scl_pkg::tok_t [scl_pkg::MAX_TOKS-1:0] toks;
	logic [scl_pkg::CNT_W-1:0]       n;
	logic                            accept;
	logic                            word_cont;

	assign accept    = push && !q_full;
	assign idle      = scl_pkg::lex_idle(cmd.ch);
	assign word_cont = scl_pkg::is_alnum(cmd.ch) || cmd.ch == scl_pkg::CH_SLASH ||
		cmd.ch == scl_pkg::CH_DOT || cmd.ch == scl_pkg::CH_UNDER;

	// next mode: mode_c is the mode after the byte, before the line end
	always_comb begin
		mode_c = mode_q;
		if (cmd.has_char) begin
			case (mode_q)
				scl_pkg::MODE_WORD: begin
					if (!word_cont) begin
						mode_c = idle.mode;
					end
				end
				scl_pkg::MODE_AMP: begin
					mode_c = (cmd.ch == scl_pkg::CH_AMP) ? scl_pkg::MODE_IDLE : idle.mode;
				end
				scl_pkg::MODE_PIPE: begin
					mode_c = (cmd.ch == scl_pkg::CH_BAR) ? scl_pkg::MODE_IDLE : idle.mode;
				end
				scl_pkg::MODE_DASH: begin
					mode_c = scl_pkg::MODE_IDLE;
				end
				default: begin
					mode_c = idle.mode;
				end
			endcase
		end
		mode_d = cmd.end_of_line ? scl_pkg::MODE_IDLE : mode_c;
	end

	// results caused by this request
	always_comb begin
		toks   = '0;
		n      = '0;
		if (cmd.has_char) begin
			case (mode_q)
				scl_pkg::MODE_WORD: begin
					if (word_cont) begin
						toks[n] = scl_pkg::mk_tok(cmd.ch, scl_pkg::KIND_WORD, 1'b0);
						n       = n + 1'b1;
					end else begin
						if (idle.emit) begin
							toks[n] = idle.tok;
							n       = n + 1'b1;
						end
					end
				end
				scl_pkg::MODE_AMP: begin
					if (cmd.ch == scl_pkg::CH_AMP) begin
						toks[0] = scl_pkg::mk_tok(scl_pkg::CH_AMP, scl_pkg::KIND_ANDAND, 1'b1);
						toks[1] = scl_pkg::mk_tok(scl_pkg::CH_AMP, scl_pkg::KIND_ANDAND, 1'b0);
						n       = 2'd2;
					end else begin
						toks[0] = scl_pkg::mk_tok(scl_pkg::CH_AMP, scl_pkg::KIND_AMP, 1'b1);
						n       = 2'd1;
						if (idle.emit) begin
							toks[n] = idle.tok;
							n       = n + 1'b1;
						end
					end
				end
				scl_pkg::MODE_PIPE: begin
					if (cmd.ch == scl_pkg::CH_BAR) begin
						toks[0] = scl_pkg::mk_tok(scl_pkg::CH_BAR, scl_pkg::KIND_OROR, 1'b1);
						toks[1] = scl_pkg::mk_tok(scl_pkg::CH_BAR, scl_pkg::KIND_OROR, 1'b0);
						n       = 2'd2;
					end else begin
						toks[0] = scl_pkg::mk_tok(scl_pkg::CH_BAR, scl_pkg::KIND_PIPE, 1'b1);
						n       = 2'd1;
						if (idle.emit) begin
							toks[n] = idle.tok;
							n       = n + 1'b1;
						end
					end
				end
				scl_pkg::MODE_DASH: begin
					toks[0] = scl_pkg::mk_tok(cmd.ch, scl_pkg::KIND_DASH, 1'b0);
					n       = 2'd1;
				end
				default: begin
					if (idle.emit) begin
						toks[0] = idle.tok;
						n       = 2'd1;
					end
				end
			endcase
		end
		if (cmd.end_of_line) begin
			// flush a held single operator before the line end
			if (mode_c == scl_pkg::MODE_AMP) begin
				toks[n] = scl_pkg::mk_tok(scl_pkg::CH_AMP, scl_pkg::KIND_AMP, 1'b1);
				n       = n + 1'b1;
			end else if (mode_c == scl_pkg::MODE_PIPE) begin
				toks[n] = scl_pkg::mk_tok(scl_pkg::CH_BAR, scl_pkg::KIND_PIPE, 1'b1);
				n       = n + 1'b1;
			end
			toks[n] = scl_pkg::mk_tok(scl_pkg::CH_NUL, scl_pkg::KIND_LINE_END, 1'b1);
			n       = n + 1'b1;
		end
		for (int i = 0; i < scl_pkg::MAX_TOKS; i++) begin
			toks[i].last = (n != '0) && (scl_pkg::CNT_W'(i) == n - 1'b1);
		end
	end

	assign q_wr.wr        = accept && (n != '0);
	assign q_wr.data.cnt  = n;
	assign q_wr.data.toks = toks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= scl_pkg::MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

// ===== rtl/core/scl_queue.sv =====
module scl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  scl_pkg::q_wr_t q_wr,
	input  logic           deq,
	output logic           full,
	output scl_pkg::q_rd_t q_rd
);

	scl_pkg::bundle_t [scl_pkg::Q_DEPTH-1:0] slot_q;
	logic [scl_pkg::Q_PTR_W-1:0]             wr_ptr_q;
	logic [scl_pkg::Q_PTR_W-1:0]             rd_ptr_q;
	logic [scl_pkg::Q_CNT_W-1:0]             cnt_q;
	logic                                    do_deq;

	assign full       = (cnt_q == scl_pkg::Q_CNT_W'(scl_pkg::Q_DEPTH));
	assign q_rd.avail = (cnt_q != '0);
	assign q_rd.data  = slot_q[rd_ptr_q];
	assign do_deq     = deq && q_rd.avail;

	always_ff @(posedge clk) begin
		if (q_wr.wr) begin
			slot_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.wr) begin
				wr_ptr_q <= (wr_ptr_q == scl_pkg::Q_PTR_W'(scl_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == scl_pkg::Q_PTR_W'(scl_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.wr && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !q_wr.wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/scl_back.sv =====
module scl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  scl_pkg::q_rd_t q_rd,
	output logic           deq,
	input  logic           pop,
	output logic           empty,
	output scl_pkg::tok_t  tok
);

	logic [scl_pkg::CNT_W-1:0] idx_q;
	logic                      out_valid_q;
	scl_pkg::tok_t             out_q;
	logic                      load;
	logic                      at_end;

	assign load   = q_rd.avail && (!out_valid_q || pop);
	assign at_end = (idx_q == q_rd.data.cnt - 1'b1);
	assign deq    = load && at_end;
	assign empty  = !out_valid_q;
	assign tok    = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= q_rd.data.toks[idx_q[$clog2(scl_pkg::MAX_TOKS)-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/shell_command_lexer.sv =====
// channel   direction  handshake           payload
// cmd       in         push / full         ch, has_char, end_of_line
// tok       out        pop / empty         tok_char, tok_kind, tok_first, last
//
// a request is taken in the cycle push is high and full is low; the front lexes it
// in that same cycle, so one request per cycle is accepted while the queue has room
// each request yields zero to three results; unless pop stalls, the back drains them
// at one per cycle; its output register limits throughput when requests yield several
// arst_n clears the lexer mode, the queue pointers and the output valid flag
// a stalled pop fills the output register, then the two-entry queue, then raises full
module shell_command_lexer (
	input  logic          clk,
	input  logic          arst_n,
	input  scl_pkg::cmd_t cmd,
	input  logic          push,
	output logic          full,
	output scl_pkg::tok_t tok,
	output logic          empty,
	input  logic          pop
);

	scl_pkg::q_wr_t q_wr;
	scl_pkg::q_rd_t q_rd;
	logic           deq;

	// front: classify each byte and build the results it causes
	scl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.push   (push),
		.q_full (full),
		.q_wr   (q_wr)
	);

	// short queue of result bundles between front and back
	scl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.deq    (deq),
		.full   (full),
		.q_rd   (q_rd)
	);

	// back: hand out the results of each bundle one at a time
	scl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.deq    (deq),
		.pop    (pop),
		.empty  (empty),
		.tok    (tok)
	);

endmodule
